### hdl/bra_pkg.sv
// Shared types and constants of the bitmap run allocator.
`timescale 1ns / 1ps

package bra_pkg;

   localparam int DATA_W  = 64;  // bits in one occupancy word
   localparam int OFS_W   = 6;   // bit offset inside a word
   localparam int MAX_RUN = 8;   // longest run that one item touches
   localparam int START_W = 10;  // width of a position or a run start
   localparam int LEN_W   = 4;   // width of the run length field
   localparam int WIDX_W  = 5;   // word index, holds the spill word past position 1023

   localparam logic [1:0] OP_READ   = 2'd0;
   localparam logic [1:0] OP_MARK   = 2'd1;
   localparam logic [1:0] OP_FREE   = 2'd2;
   localparam logic [1:0] OP_SEARCH = 2'd3;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_READ,
      CMD_MARK,
      CMD_FREE,
      CMD_SEARCH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [WIDX_W-1:0]  word;
      logic [OFS_W-1:0]   offset;
      logic [LEN_W-1:0]   run_len;
      logic [START_W-1:0] limit;
   } cmd_type;

   typedef struct packed {
      logic               bit_value;
      logic               found;
      logic [START_W-1:0] run_start;
   } rsp_type;

endpackage

### hdl/bra_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bra_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bra_front.sv
// Front end: accepts request items and classifies them into commands.
`timescale 1ns / 1ps

module bra_front #(
   parameter int WORDS = 16
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_operation,
   input  logic [bra_pkg::START_W-1:0]  req_position,
   input  logic [bra_pkg::LEN_W-1:0]    req_run_length,
   input  logic                         queue_full,
   input  logic                         clearing,
   output logic                         push,
   output bra_pkg::cmd_type             cmd
);

   localparam int MAP_BITS  = WORDS * bra_pkg::DATA_W;
   localparam int START_MAX = (1 << bra_pkg::START_W) - 1;

   logic [bra_pkg::LEN_W-1:0]   run_len;
   logic [bra_pkg::WIDX_W-1:0]  word;
   logic [bra_pkg::START_W-1:0] limit;
   logic                        in_map;

   assign req_stall = queue_full || clearing;
   assign push      = req_valid && !req_stall;

   assign run_len = (req_run_length > bra_pkg::LEN_W'(bra_pkg::MAX_RUN)) ?
                    bra_pkg::LEN_W'(bra_pkg::MAX_RUN) : req_run_length;
   assign word    = bra_pkg::WIDX_W'(req_position[bra_pkg::START_W-1:bra_pkg::OFS_W]);
   assign in_map  = word < WORDS;

   // The last start worth trying: the run must fit in the map and be reportable.
   always_comb begin
      int span;
      span  = MAP_BITS - int'(run_len);
      limit = (span > START_MAX) ? bra_pkg::START_W'(START_MAX) : bra_pkg::START_W'(span);
   end

   always_comb begin
      cmd.word    = word;
      cmd.offset  = req_position[bra_pkg::OFS_W-1:0];
      cmd.run_len = run_len;
      cmd.limit   = limit;
      unique case (req_operation)
         bra_pkg::OP_READ: begin
            cmd.kind = in_map ? bra_pkg::CMD_READ : bra_pkg::CMD_NONE;
         end
         bra_pkg::OP_MARK: begin
            cmd.kind = (in_map && run_len != '0) ? bra_pkg::CMD_MARK : bra_pkg::CMD_NONE;
         end
         bra_pkg::OP_FREE: begin
            cmd.kind = (in_map && run_len != '0) ? bra_pkg::CMD_FREE : bra_pkg::CMD_NONE;
         end
         bra_pkg::OP_SEARCH: begin
            cmd.kind = (run_len != '0 && req_position <= limit) ?
                       bra_pkg::CMD_SEARCH : bra_pkg::CMD_NONE;
         end
      endcase
   end

endmodule

### hdl/bra_queue.sv
// Two-entry command queue between the front end and the back end.
`timescale 1ns / 1ps

module bra_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bra_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output bra_pkg::cmd_type head
);

   bra_pkg::cmd_type entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

### hdl/bra_back.sv
// Back end: runs commands against the occupancy RAM and holds the result register.
`timescale 1ns / 1ps

module bra_back #(
   parameter int WORDS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        queue_valid,
   input  bra_pkg::cmd_type            queue_head,
   output logic                        queue_pop,
   output logic                        clearing,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_bit_value,
   output logic                        rsp_found,
   output logic [bra_pkg::START_W-1:0] rsp_run_start
);

   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int DW     = bra_pkg::DATA_W;
   localparam int RUN    = bra_pkg::MAX_RUN;

   typedef enum logic [6:0] {
      ST_CLEAR = 7'b0000001,
      ST_IDLE  = 7'b0000010,
      ST_RDATA = 7'b0000100,
      ST_WR0   = 7'b0001000,
      ST_WR1   = 7'b0010000,
      ST_PRIME = 7'b0100000,
      ST_SCAN  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   bra_pkg::cmd_type            cmd_ff, cmd_in;
   logic [ADDR_W-1:0]           clr_ff, clr_in;
   logic [bra_pkg::WIDX_W-1:0]  rd_ff, rd_in;
   logic [bra_pkg::WIDX_W-1:0]  eval_ff, eval_in;
   logic [DW-1:0]               cur_ff, cur_in;
   logic [bra_pkg::OFS_W-1:0]   lo_ff, lo_in;
   logic                        nxt_ok_ff, nxt_ok_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   bra_pkg::rsp_type            rsp_ff, rsp_in;

   logic                        wr_en;
   logic [ADDR_W-1:0]           wr_addr;
   logic [DW-1:0]               wr_data;
   logic [ADDR_W-1:0]           rd_addr;
   logic [DW-1:0]               rd_data;

   logic                        out_free;
   logic                        emit;
   bra_pkg::rsp_type            emit_val;
   logic [RUN-1:0]              len_mask;
   logic [DW+RUN-1:0]           run_mask;
   logic [bra_pkg::WIDX_W-1:0]  word_next;
   logic                        spill;
   logic [DW-1:0]               nxt_word;
   logic [DW+RUN-1:0]           window;
   logic [DW-1:0]               free_vec;
   logic [DW-1:0]               ge_mask;
   logic [DW-1:0]               le_mask;
   logic [DW-1:0]               cand;
   logic                        last_word;
   logic                        hit;
   logic [bra_pkg::OFS_W-1:0]   hit_idx;

   bra_ram #(
      .WIDTH (DW),
      .DEPTH (WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign clearing  = state_ff == ST_CLEAR;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   // A command starts only when the result register will be free for it.
   assign queue_pop = (state_ff == ST_IDLE) && queue_valid && out_free;

   assign len_mask  = RUN'((9'd1 << cmd_ff.run_len) - 9'd1);
   assign run_mask  = (DW + RUN)'(len_mask) << cmd_ff.offset;
   assign word_next = cmd_ff.word + 1'b1;
   assign spill     = (|run_mask[DW+RUN-1:DW]) && (word_next < WORDS);

   // Search window: the word under test plus the low bits of the word after it.
   assign nxt_word  = nxt_ok_ff ? rd_data : '0;
   assign window    = {nxt_word[RUN-1:0], cur_ff};
   assign last_word = eval_ff[3:0] == cmd_ff.limit[bra_pkg::START_W-1:bra_pkg::OFS_W];
   assign ge_mask   = {DW{1'b1}} << lo_ff;
   assign le_mask   = last_word ?
                      ({DW{1'b1}} >> (6'd63 - cmd_ff.limit[bra_pkg::OFS_W-1:0])) : {DW{1'b1}};

   always_comb begin
      for (int i = 0; i < DW; i++) begin
         free_vec[i] = (window[i +: RUN] & len_mask) == '0;
      end
   end

   assign cand = free_vec & ge_mask & le_mask;
   assign hit  = |cand;

   always_comb begin
      hit_idx = '0;
      for (int i = DW - 1; i >= 0; i--) begin
         if (cand[i]) begin
            hit_idx = bra_pkg::OFS_W'(i);
         end
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd_in    = cmd_ff;
      clr_in    = clr_ff;
      rd_in     = rd_ff;
      eval_in   = eval_ff;
      cur_in    = cur_ff;
      lo_in     = lo_ff;
      nxt_ok_in = nxt_ok_ff;
      wr_en     = 1'b0;
      wr_addr   = clr_ff;
      wr_data   = '0;
      rd_addr   = ADDR_W'(queue_head.word);
      emit      = 1'b0;
      emit_val  = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(WORDS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (queue_pop) begin
               cmd_in = queue_head;
               unique case (queue_head.kind)
                  bra_pkg::CMD_READ: begin
                     state_in = ST_RDATA;
                  end
                  bra_pkg::CMD_MARK,
                  bra_pkg::CMD_FREE: begin
                     state_in = ST_WR0;
                  end
                  bra_pkg::CMD_SEARCH: begin
                     rd_in    = queue_head.word + 1'b1;
                     eval_in  = queue_head.word;
                     lo_in    = queue_head.offset;
                     state_in = ST_PRIME;
                  end
                  default: begin
                     emit = 1'b1;
                  end
               endcase
            end
         end
         ST_RDATA: begin
            emit               = 1'b1;
            emit_val.bit_value = rd_data[cmd_ff.offset];
            state_in           = ST_IDLE;
         end
         ST_WR0: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(cmd_ff.word);
            wr_data = (cmd_ff.kind == bra_pkg::CMD_MARK) ? (rd_data | run_mask[DW-1:0]) :
                                                           (rd_data & ~run_mask[DW-1:0]);
            rd_addr = ADDR_W'(word_next);
            if (spill) begin
               state_in = ST_WR1;
            end else begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WR1: begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(word_next);
            wr_data = (cmd_ff.kind == bra_pkg::CMD_MARK) ?
               {rd_data[DW-1:RUN], rd_data[RUN-1:0] | run_mask[DW+RUN-1:DW]} :
               {rd_data[DW-1:RUN], rd_data[RUN-1:0] & ~run_mask[DW+RUN-1:DW]};
            emit     = 1'b1;
            state_in = ST_IDLE;
         end
         ST_PRIME: begin
            cur_in    = rd_data;
            rd_addr   = ADDR_W'(rd_ff);
            nxt_ok_in = rd_ff < WORDS;
            rd_in     = rd_ff + 1'b1;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            if (hit) begin
               emit               = 1'b1;
               emit_val.found     = 1'b1;
               emit_val.run_start = {eval_ff[3:0], hit_idx};
               state_in           = ST_IDLE;
            end else if (last_word) begin
               emit     = 1'b1;
               state_in = ST_IDLE;
            end else begin
               cur_in    = nxt_word;
               eval_in   = eval_ff + 1'b1;
               lo_in     = '0;
               rd_addr   = ADDR_W'(rd_ff);
               nxt_ok_in = rd_ff < WORDS;
               rd_in     = rd_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_in       = emit_val;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
         rsp_in       = rsp_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      rd_ff     <= rd_in;
      eval_ff   <= eval_in;
      cur_ff    <= cur_in;
      lo_ff     <= lo_in;
      nxt_ok_ff <= nxt_ok_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_bit_value = rsp_ff.bit_value;
   assign rsp_found     = rsp_ff.found;
   assign rsp_run_start = rsp_ff.run_start;

endmodule

### hdl/bitmap_run_allocator.sv
// Top level of the bitmap run allocator: front end, command queue and back end.
// Commands that need no map access answer without touching the RAM; a bit read reads
// one word; mark and free rewrite the addressed word and, when the run spills, the next;
// a search scans word by word. The queue takes new items while the back end is busy.
// Reset is synchronous; after it a clearing pass writes zero to all WORDS words,
// during which req_stall stays high.
`timescale 1ns / 1ps

module bitmap_run_allocator #(
   parameter int WORDS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_operation,
   input  logic [bra_pkg::START_W-1:0] req_position,
   input  logic [bra_pkg::LEN_W-1:0]   req_run_length,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_bit_value,
   output logic                        rsp_found,
   output logic [bra_pkg::START_W-1:0] rsp_run_start
);

   bra_pkg::cmd_type front_cmd;
   bra_pkg::cmd_type queue_head;
   logic             push;
   logic             queue_full;
   logic             queue_valid;
   logic             queue_pop;
   logic             clearing;

   bra_front #(
      .WORDS (WORDS)
   ) u_front (
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_position   (req_position),
      .req_run_length (req_run_length),
      .queue_full     (queue_full),
      .clearing       (clearing),
      .push           (push),
      .cmd            (front_cmd)
   );

   bra_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (front_cmd),
      .full      (queue_full),
      .pop       (queue_pop),
      .not_empty (queue_valid),
      .head      (queue_head)
   );

   bra_back #(
      .WORDS (WORDS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_valid   (queue_valid),
      .queue_head    (queue_head),
      .queue_pop     (queue_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_bit_value (rsp_bit_value),
      .rsp_found     (rsp_found),
      .rsp_run_start (rsp_run_start)
   );

endmodule
